// File: hdl/ibc_pkg.sv
// Shared widths, limits and reset values for the inertial bias calibrator.
`timescale 1ns / 1ps
`default_nettype none

package ibc_pkg;

  // raw sample and register widths
  localparam int unsigned RAW_W   = 16;
  localparam int unsigned AXES    = 3;
  localparam int unsigned SUM_W   = 24;
  localparam int unsigned BIAS_W  = 24;
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned GOUT_W  = 25;
  localparam int unsigned AOUT_W  = 22;
  localparam int unsigned PROD_W  = 2 * RAW_W;
  localparam int unsigned ASHIFT  = 7;

  // stream widths
  localparam int unsigned S_TDATA_W = 6 * RAW_W;
  localparam int unsigned M_TDATA_W = 144;
  localparam int unsigned M_USED_W  = AXES * GOUT_W + AXES * AOUT_W;

  // accelerometer gain reset, about -9.81/56 in Q1.15
  localparam logic signed [RAW_W-1:0] ACCEL_SCALE_RESET = -16'sd5740;

  // saturation limits of the scaled accelerometer value
  localparam logic signed [PROD_W-1:0] ACC_MAX = 32'sd2097151;
  localparam logic signed [PROD_W-1:0] ACC_MIN = -32'sd2097152;

  typedef logic signed [RAW_W-1:0]  raw_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [BIAS_W-1:0] bias_t;
  typedef logic signed [GOUT_W-1:0] gout_t;
  typedef logic signed [AOUT_W-1:0] aout_t;

endpackage

`default_nettype wire

// File: hdl/inertial_bias_calibrator_top.sv
// Top level: gyro bias removal, accelerometer scaling and startup bias calibration.
//
// Channel   Dir  Group                  Contents
// s_axis    in   tvalid/tready/tdata    six raw samples, one frame per transfer
// m_axis    out  tvalid/tready/tdata    three gyro Q.8 and three accel Q.8 values
//                tuser                  calibrated flag as it stood before the frame
// cfg       in   cfg_wr_en/cfg_wr_data  accelerometer gain, Q1.15
//
// One frame per cycle when nothing stalls, through an input register and then a
// result register to m_axis. s_axis_tready drops while the input register holds
// a frame that cannot move on (result stalled or bias unit busy). When the CAL_FRAMES-th
// frame moves on, the bias means are formed by reciprocal multiplication in the quotient,
// remainder and fraction states, once after reset; the next frame waits until they end.
// Reset (rst, synchronous) empties both registers and clears sums, bias and flag.
`timescale 1ns / 1ps
`default_nettype none

module inertial_bias_calibrator_top #(
  parameter int unsigned CAL_FRAMES = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // cfg write port
  input  wire logic                             cfg_wr_en,
  input  wire logic [ibc_pkg::RAW_W-1:0]        cfg_wr_data,
  // input stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // raw_gyro_x, raw_gyro_y, raw_gyro_z, raw_accel_x, raw_accel_y, raw_accel_z
  input  wire logic [ibc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // output stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // gyro_out_x, gyro_out_y, gyro_out_z, accel_out_x, accel_out_y, accel_out_z, zero pad
  output logic [ibc_pkg::M_TDATA_W-1:0]         m_axis_tdata,
  // is_calibrated
  output logic                                  m_axis_tuser
);

  localparam int unsigned CW   = $clog2(CAL_FRAMES + 1);  // frame counter width
  localparam int unsigned AX   = ibc_pkg::AXES;
  localparam int unsigned LOGN = $clog2(CAL_FRAMES);
  // offset that makes the window sum non-negative
  localparam int unsigned MEAN_OFS = CAL_FRAMES << (ibc_pkg::RAW_W - 1);
  // numerator of the fractional step: remainder above, N/2 below
  localparam int unsigned FNW  = 2 * ibc_pkg::FRAC_W;
  localparam int unsigned SH1  = ibc_pkg::SUM_W + LOGN;
  localparam int unsigned SH2  = FNW + LOGN;
  localparam int unsigned R1W  = ibc_pkg::SUM_W + 1;
  localparam int unsigned R2W  = FNW + 1;
  localparam int unsigned P1W  = ibc_pkg::SUM_W + R1W;
  localparam int unsigned P2W  = FNW + R2W;
  // rounded-up reciprocals, exact floor division over the operand ranges
  localparam logic [R1W-1:0] RECIP1 =
    R1W'(((64'd1 << SH1) + 64'(CAL_FRAMES) - 64'd1) / 64'(CAL_FRAMES));
  localparam logic [R2W-1:0] RECIP2 =
    R2W'(((64'd1 << SH2) + 64'(CAL_FRAMES) - 64'd1) / 64'(CAL_FRAMES));

  typedef enum logic [1:0] {
    CAL_IDLE,
    CAL_QUOT,
    CAL_REM,
    CAL_FRAC
  } cal_state_t;

  // configuration
  ibc_pkg::raw_t  accel_scale;

  // input register
  logic           s1_valid;
  ibc_pkg::raw_t  s1_gyro  [AX];
  ibc_pkg::raw_t  s1_accel [AX];

  // result register
  logic           s2_valid;
  ibc_pkg::gout_t gyro_out  [AX];
  ibc_pkg::aout_t accel_out [AX];
  logic           cal_out;

  // calibration state
  ibc_pkg::sum_t  sums [AX];
  ibc_pkg::bias_t bias [AX];
  logic [CW-1:0]  frame_count;
  logic           calibrated;

  // bias unit
  cal_state_t                  cal_state;
  logic                        busy;
  logic [ibc_pkg::SUM_W-1:0]   mean_x   [AX];
  logic [ibc_pkg::RAW_W-1:0]   mean_q   [AX];
  logic [FNW-1:0]              frac_num [AX];

  // combinational
  logic                advance;
  logic                last_frame;
  ibc_pkg::sum_t       sum_next   [AX];
  ibc_pkg::gout_t      gyro_next  [AX];
  ibc_pkg::aout_t      accel_next [AX];
  logic signed [ibc_pkg::PROD_W-1:0] prod    [AX];
  logic signed [ibc_pkg::PROD_W-1:0] shifted [AX];
  logic [P1W-1:0]              prod1    [AX];
  logic [ibc_pkg::FRAC_W-1:0]  mean_rem [AX];
  logic [P2W-1:0]              prod2    [AX];
  logic [ibc_pkg::FRAC_W-1:0]  frac_q   [AX];

  // handshake: frames pass the input register unless the result is stalled or the bias unit is running
  assign busy          = (cal_state != CAL_IDLE);
  assign advance       = s1_valid && (!s2_valid || m_axis_tready) && !busy;
  assign s_axis_tready = !s1_valid || advance;
  assign last_frame    = advance && !calibrated && (frame_count == CW'(CAL_FRAMES - 1));

  // per-axis datapath
  always_comb begin
    for (int i = 0; i < AX; i++) begin
      // gyro: raw in Q.8 minus bias
      gyro_next[i] = {s1_gyro[i][ibc_pkg::RAW_W-1], s1_gyro[i], 8'b0}
                   - {bias[i][ibc_pkg::BIAS_W-1], bias[i]};
      // accel: gain product, floor shift, saturate
      prod[i]    = s1_accel[i] * accel_scale;
      shifted[i] = prod[i] >>> ibc_pkg::ASHIFT;
      if (shifted[i] > ibc_pkg::ACC_MAX) begin
        accel_next[i] = ibc_pkg::AOUT_W'(ibc_pkg::ACC_MAX);
      end else if (shifted[i] < ibc_pkg::ACC_MIN) begin
        accel_next[i] = ibc_pkg::AOUT_W'(ibc_pkg::ACC_MIN);
      end else begin
        accel_next[i] = ibc_pkg::AOUT_W'(shifted[i]);
      end
      // running sum, restarted at the first frame of the window
      sum_next[i] = ((frame_count == '0) ? ibc_pkg::sum_t'(0) : sums[i])
                  + {{(ibc_pkg::SUM_W - ibc_pkg::RAW_W){s1_gyro[i][ibc_pkg::RAW_W-1]}},
                     s1_gyro[i]};
      // integer part: offset sum over N, by reciprocal
      prod1[i]    = {{R1W{1'b0}}, mean_x[i]} * {{ibc_pkg::SUM_W{1'b0}}, RECIP1};
      // remainder of the integer part, below N
      mean_rem[i] = ibc_pkg::FRAC_W'(mean_x[i]
                  - ibc_pkg::SUM_W'(mean_q[i] * CAL_FRAMES));
      // fraction: (remainder*256 + N/2) over N
      prod2[i]    = {{R2W{1'b0}}, frac_num[i]} * {{FNW{1'b0}}, RECIP2};
      frac_q[i]   = prod2[i][SH2 +: ibc_pkg::FRAC_W];
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      for (int i = 0; i < AX; i++) begin
        s1_gyro[i]  <= s_axis_tdata[i*ibc_pkg::RAW_W +: ibc_pkg::RAW_W];
        s1_accel[i] <= s_axis_tdata[(i+AX)*ibc_pkg::RAW_W +: ibc_pkg::RAW_W];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= 1'b1;
    end else if (m_axis_tready) begin
      s2_valid <= 1'b0;
    end
    if (advance) begin
      gyro_out  <= gyro_next;
      accel_out <= accel_next;
      cal_out   <= calibrated;
    end
  end

  // gain register
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_scale <= ibc_pkg::ACCEL_SCALE_RESET;
    end else if (cfg_wr_en) begin
      accel_scale <= cfg_wr_data;
    end
  end

  // calibration window and bias unit
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      calibrated  <= 1'b0;
      cal_state   <= CAL_IDLE;
      for (int i = 0; i < AX; i++) begin
        sums[i] <= '0;
        bias[i] <= '0;
      end
    end else begin
      unique case (cal_state)
        CAL_IDLE: begin
          if (advance && !calibrated) begin
            sums <= sum_next;
            if (last_frame) begin
              frame_count <= '0;
              cal_state   <= CAL_QUOT;
              for (int i = 0; i < AX; i++) begin
                mean_x[i] <= sum_next[i] + ibc_pkg::SUM_W'(MEAN_OFS);
              end
            end else begin
              frame_count <= frame_count + 1'b1;
            end
          end
        end
        CAL_QUOT: begin
          for (int i = 0; i < AX; i++) begin
            mean_q[i] <= prod1[i][SH1 +: ibc_pkg::RAW_W];
          end
          cal_state <= CAL_REM;
        end
        CAL_REM: begin
          for (int i = 0; i < AX; i++) begin
            frac_num[i] <= {mean_rem[i], ibc_pkg::FRAC_W'(CAL_FRAMES / 2)};
          end
          cal_state <= CAL_FRAC;
        end
        CAL_FRAC: begin
          // integer part back from offset form, fraction below it
          for (int i = 0; i < AX; i++) begin
            bias[i] <= {~mean_q[i][ibc_pkg::RAW_W-1], mean_q[i][ibc_pkg::RAW_W-2:0],
                        frac_q[i]};
          end
          calibrated <= 1'b1;
          cal_state  <= CAL_IDLE;
        end
      endcase
    end
  end

  // output packing
  assign m_axis_tvalid = s2_valid;
  assign m_axis_tuser  = cal_out;
  assign m_axis_tdata  = {(ibc_pkg::M_TDATA_W - ibc_pkg::M_USED_W)'(0),
                          accel_out[2], accel_out[1], accel_out[0],
                          gyro_out[2], gyro_out[1], gyro_out[0]};

endmodule

`default_nettype wire

// File: hdl/ibc_checker.sv
// Port-level checker for the inertial bias calibrator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ibc_checker #(
  parameter int unsigned CAL_FRAMES = 64
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [ibc_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input wire logic                          m_axis_tuser
);

  localparam int unsigned OCW = $clog2(CAL_FRAMES + 1);

  logic           in_xfer;
  logic           out_xfer;
  logic [1:0]     pending;
  logic [OCW-1:0] out_count;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // frames inside the block and results delivered so far
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      out_count <= '0;
    end else begin
      pending <= pending + {1'b0, in_xfer} - {1'b0, out_xfer};
      if (out_xfer && (out_count != OCW'(CAL_FRAMES))) begin
        out_count <= out_count + 1'b1;
      end
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("output changed while stalled");

  // at most two frames in flight
  a_pending: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two frames held");

  // flag is clear for the calibration window and set for every frame after it
  a_flag: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> (m_axis_tuser == (out_count == OCW'(CAL_FRAMES))))
    else $error("calibrated flag out of step with frame count");

  // nothing leaves without an input transfer
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pending != 2'd0)
    else $error("result with no frame accepted");

  // reset empties the output
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind inertial_bias_calibrator_top ibc_checker #(
  .CAL_FRAMES(CAL_FRAMES)
) u_ibc_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire

// File: tb/sv/inertial_bias_calibrator_top_test.sv
// Self-checking testbench for inertial_bias_calibrator_top: startup bias, scaling, handshakes.
`timescale 1ns / 1ps

module inertial_bias_calibrator_top_test;

  localparam int CAL_FRAMES   = 64;
  localparam int SETTLE_CYCLES = 48;   // covers the input and result registers and the bias unit
  localparam int RANDOM_PER_PHASE = 80;

  typedef struct {
    ibc_pkg::raw_t gyro  [ibc_pkg::AXES];
    ibc_pkg::raw_t accel [ibc_pkg::AXES];
  } frame_t;

  typedef struct {
    ibc_pkg::gout_t gyro  [ibc_pkg::AXES];
    ibc_pkg::aout_t accel [ibc_pkg::AXES];
    logic           cal;
  } reading_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_wr_en = 1'b0;
  logic [ibc_pkg::RAW_W-1:0]      cfg_wr_data = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [ibc_pkg::S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [ibc_pkg::M_TDATA_W-1:0]  m_axis_tdata;
  logic                           m_axis_tuser;

  // frames waiting to be sent, readings waiting to come back
  frame_t   frame_q [$];
  reading_t reading_q [$];
  int       errors = 0;

  // mirror of the block state
  ibc_pkg::raw_t accel_gain = ibc_pkg::ACCEL_SCALE_RESET;
  longint        gyro_sum [ibc_pkg::AXES];
  longint        bias_q8 [ibc_pkg::AXES];
  int unsigned   frames_summed = 0;
  bit            calibrated = 1'b0;

  // sender and receiver pacing
  frame_t   held_frame;
  bit       sending = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       stall_cycles = 0;
  logic [7:0] stall_pat = 8'hFF;

  string AXIS_NAME [ibc_pkg::AXES] = '{"x", "y", "z"};

  inertial_bias_calibrator_top #(
    .CAL_FRAMES (CAL_FRAMES)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    // raw_gyro_x, raw_gyro_y, raw_gyro_z, raw_accel_x, raw_accel_y, raw_accel_z
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // gyro_out_x/y/z, accel_out_x/y/z, zero pad
    .m_axis_tdata  (m_axis_tdata),
    // is_calibrated
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // expected reading for one frame; advances the calibration state
  function automatic reading_t correct_frame(frame_t f);
    reading_t r;
    longint   scaled;
    longint   num;
    longint   q;
    for (int i = 0; i < ibc_pkg::AXES; i++) begin
      r.gyro[i] = ibc_pkg::gout_t'(longint'(f.gyro[i]) * 256 - bias_q8[i]);
      // floor division by 128, then clamp to the output range
      scaled = (longint'(f.accel[i]) * longint'(accel_gain)) >>> ibc_pkg::ASHIFT;
      if (scaled > longint'(ibc_pkg::ACC_MAX)) begin
        scaled = longint'(ibc_pkg::ACC_MAX);
      end else if (scaled < longint'(ibc_pkg::ACC_MIN)) begin
        scaled = longint'(ibc_pkg::ACC_MIN);
      end
      r.accel[i] = ibc_pkg::aout_t'(scaled);
    end
    r.cal = calibrated;
    if (!calibrated) begin
      // a new window starts from cleared sums
      if (frames_summed == 0) begin
        for (int i = 0; i < ibc_pkg::AXES; i++) gyro_sum[i] = 0;
      end
      for (int i = 0; i < ibc_pkg::AXES; i++) gyro_sum[i] += longint'(f.gyro[i]);
      frames_summed++;
      if (frames_summed >= CAL_FRAMES) begin
        // Q.8 mean, rounded half up
        for (int i = 0; i < ibc_pkg::AXES; i++) begin
          num = gyro_sum[i] * 256 + CAL_FRAMES / 2;
          q = num / CAL_FRAMES;
          if ((num % CAL_FRAMES) != 0 && num < 0) q--;
          bias_q8[i] = q;
        end
        frames_summed = 0;
        calibrated = 1'b1;
      end
    end
    return r;
  endfunction

  // mostly full-range values, with extremes and small values mixed in
  function automatic ibc_pkg::raw_t rand_raw();
    case ($urandom_range(0, 9))
      0: return ibc_pkg::raw_t'(16'h7FFF);
      1: return ibc_pkg::raw_t'(16'h8000);
      2: return ibc_pkg::raw_t'(int'($urandom_range(0, 16)) - 8);
      default: return ibc_pkg::raw_t'($urandom);
    endcase
  endfunction

  function automatic void queue_frame(int gx, int gy, int gz, int ax, int ay, int az);
    frame_t f;
    f.gyro[0]  = ibc_pkg::raw_t'(gx);
    f.gyro[1]  = ibc_pkg::raw_t'(gy);
    f.gyro[2]  = ibc_pkg::raw_t'(gz);
    f.accel[0] = ibc_pkg::raw_t'(ax);
    f.accel[1] = ibc_pkg::raw_t'(ay);
    f.accel[2] = ibc_pkg::raw_t'(az);
    frame_q.push_back(f);
  endfunction

  function automatic void queue_random(int count);
    frame_t f;
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < ibc_pkg::AXES; i++) begin
        f.gyro[i]  = rand_raw();
        f.accel[i] = rand_raw();
      end
      frame_q.push_back(f);
    end
  endfunction

  function automatic void note_mismatch(string field, longint want, longint got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    errors++;
  endfunction

  task automatic wait_idle();
    while (frame_q.size() != 0 || sending || reading_q.size() != 0) @(posedge clk);
  endtask

  // sender: bursts of random length, random gaps between them
  always @(posedge clk) begin
    logic [ibc_pkg::S_TDATA_W-1:0] word;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      sending = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        reading_q.push_back(correct_frame(held_frame));
        sending = 1'b0;
      end
      if (!sending) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (frame_q.size() != 0) begin
          held_frame = frame_q.pop_front();
          for (int i = 0; i < ibc_pkg::AXES; i++) begin
            word[i * ibc_pkg::RAW_W +: ibc_pkg::RAW_W] = held_frame.gyro[i];
            word[(ibc_pkg::AXES + i) * ibc_pkg::RAW_W +: ibc_pkg::RAW_W] =
              held_frame.accel[i];
          end
          s_axis_tdata  <= word;
          s_axis_tvalid <= 1'b1;
          sending = 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: rotating ready pattern, redrawn at random when its countdown runs out
  always @(posedge clk) begin
    if (stall_cycles == 0) begin
      stall_cycles = $urandom_range(16, 96);
      case ($urandom_range(0, 3))
        0: stall_pat = 8'hFF;
        1: stall_pat = 8'h01;
        default: stall_pat = 8'($urandom) | 8'h10;
      endcase
    end else begin
      stall_cycles--;
    end
    stall_pat = {stall_pat[6:0], stall_pat[7]};
    m_axis_tready <= stall_pat[0];
  end

  // output check against the oldest expected reading
  always @(posedge clk) begin
    reading_t       want;
    ibc_pkg::gout_t g;
    ibc_pkg::aout_t a;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (reading_q.size() == 0) begin
        $display("%0t: output transfer with nothing expected, tdata=%h tuser=%b",
                 $time, m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = reading_q.pop_front();
        for (int i = 0; i < ibc_pkg::AXES; i++) begin
          g = m_axis_tdata[i * ibc_pkg::GOUT_W +: ibc_pkg::GOUT_W];
          a = m_axis_tdata[ibc_pkg::AXES * ibc_pkg::GOUT_W + i * ibc_pkg::AOUT_W
                           +: ibc_pkg::AOUT_W];
          if (g !== want.gyro[i])
            note_mismatch({"gyro_out_", AXIS_NAME[i]}, want.gyro[i], g);
          if (a !== want.accel[i])
            note_mismatch({"accel_out_", AXIS_NAME[i]}, want.accel[i], a);
        end
        if (m_axis_tuser !== want.cal)
          note_mismatch("is_calibrated", want.cal, m_axis_tuser);
      end
    end
  end

  // stimulus: calibration window under the reset gain, then one phase per gain setting
  initial begin
    ibc_pkg::raw_t gains [6];
    gains[0] = ibc_pkg::raw_t'(16'h7FFF);
    gains[1] = ibc_pkg::raw_t'(16'h8000);
    gains[2] = '0;
    gains[3] = ibc_pkg::raw_t'($urandom);
    gains[4] = ibc_pkg::raw_t'(1);
    gains[5] = ibc_pkg::ACCEL_SCALE_RESET;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // field extremes and bit patterns, all inside the calibration window
    queue_frame(0, 0, 0, 0, 0, 0);
    queue_frame(32767, 32767, 32767, 32767, 32767, 32767);
    queue_frame(-32768, -32768, -32768, -32768, -32768, -32768);
    queue_frame(32767, -32768, -1, -1, 1, 0);
    queue_frame(1, -1, 0, -32768, 32767, -1);
    queue_frame(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    queue_frame(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    repeat (6) queue_frame(32767, -32768, 32767, 1, -1, 2);
    queue_frame(-1, -1, -1, -1, -1, -1);
    queue_random(120 - frame_q.size());

    foreach (gains[p]) begin
      // sender holds until every reading is back, then the gain changes
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clk);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= gains[p];
      accel_gain = gains[p];
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      if (p < 2) begin
        queue_frame(32767, -32768, 0, 32767, -32768, -1);
        queue_frame(-32768, 32767, 1, -32768, 32767, 1);
      end
      queue_random(RANDOM_PER_PHASE);
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("inertial_bias_calibrator_top verification clean");
    end else begin
      $display("inertial_bias_calibrator_top verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d readings still expected", $time, reading_q.size());
    $display("inertial_bias_calibrator_top verification failed");
    $finish;
  end

endmodule
